// File: hw/rtl/quaternion_to_euler_angles_assert.svh
// Assertion macros for the quaternion to Euler angle converter
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define QTE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define QTE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/qte_pkg.sv
// Shared constants, tables and payload types for the quaternion to Euler angle converter
package qte_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN = 24;
	localparam int ZW = 34;
	localparam int SQRT_STEPS = 29;
	localparam int CORDIC_LAT = CORDIC_STAGES + 1;
	localparam int PITCH_PRE = 4 + SQRT_STEPS;
	localparam int ROLL_DELAY = PITCH_PRE - 2;
	localparam int S28_DELAY = SQRT_STEPS + 1;
	localparam int SCALE_LAT = 3;
	localparam int TOTAL_LAT = PITCH_PRE + CORDIC_LAT + SCALE_LAT;

	localparam logic signed [63:0] ONE_Q56 = 64'sh0100_0000_0000_0000;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic [15:0] SCALE_NUM = 16'd36672;
	localparam logic [49:0] SCALE_HALF = 50'd2684354560;
	localparam logic [21:0] RECIP_5 = 22'd3355443;

	localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	typedef struct packed {
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic               quat_present;
	} quat_t;

	typedef struct packed {
		logic signed [14:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic signed [15:0] yaw_angle;
	} angles_t;

endpackage

// File: hw/rtl/qte_sqrt.sv
// Pipelined integer square root, one result bit per stage
module qte_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [56:0] v_in,
	output logic [28:0] root
);

	logic [57:0] rem_s [qte_pkg::SQRT_STEPS+1];
	logic [57:0] res_s [qte_pkg::SQRT_STEPS+1];

	assign rem_s[0] = {1'b0, v_in};
	assign res_s[0] = '0;

	for (genvar k = 0; k < qte_pkg::SQRT_STEPS; k++) begin : g_step
		localparam logic [57:0] BIT = 58'(1) << (56 - 2 * k);
		logic [57:0] sum;
		assign sum = res_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[k] >= sum) begin
					rem_s[k+1] <= rem_s[k] - sum;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1] <= rem_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	assign root = res_s[qte_pkg::SQRT_STEPS][28:0];

endmodule

// File: hw/rtl/qte_cordic.sv
// Pipelined vectoring CORDIC giving atan2 in Q30 radians
module qte_cordic (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [63:0]            y_in,
	input  logic signed [63:0]            x_in,
	output logic signed [qte_pkg::ZW-1:0] z_out
);

	logic signed [63:0]            x_s [qte_pkg::CORDIC_STAGES+1];
	logic signed [63:0]            y_s [qte_pkg::CORDIC_STAGES+1];
	logic signed [qte_pkg::ZW-1:0] z_s [qte_pkg::CORDIC_STAGES+1];
	logic                          zero_s [qte_pkg::CORDIC_STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= y_in;
					y_s[0] <= -x_in;
					z_s[0] <= qte_pkg::HALF_PI_Q30;
				end else begin
					x_s[0] <= -y_in;
					y_s[0] <= x_in;
					z_s[0] <= -qte_pkg::HALF_PI_Q30;
				end
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < qte_pkg::CORDIC_STAGES; i++) begin : g_stage
		localparam logic signed [qte_pkg::ZW-1:0] ANG =
			$signed({2'b00, qte_pkg::ATAN_Q30[i]});
		logic signed [63:0] xs;
		logic signed [63:0] ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + ANG;
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - ANG;
				end
			end
		end
	end

	assign z_out = zero_s[qte_pkg::CORDIC_STAGES] ? '0 : z_s[qte_pkg::CORDIC_STAGES];

endmodule

// File: hw/rtl/quaternion_to_euler_angles.sv
// Top level: quaternion (Q30) to ZYX Euler angles in 1/128 degree, fully pipelined
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+----------------------
//  input   | quat_valid  | quat_ready  | quat   (qte_pkg::quat_t)
//  output  | angle_valid | angle_ready | angles (qte_pkg::angles_t)
//
// One transfer per cycle in each direction while the output is not stalled. Pipeline, with 16 CORDIC stages:
// 4 product/sum stages, 29 square root stages, CORDIC stages + 1, 3 scaling stages.
// A stalled output holds every stage; the pipeline advances when the last stage is empty
// or taken. Samples without a quaternion are dropped at entry. Reset clears valid bits only.
module quaternion_to_euler_angles (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             quat_valid,
	output logic             quat_ready,
	input  qte_pkg::quat_t   quat,
	output logic             angle_valid,
	input  logic             angle_ready,
	output qte_pkg::angles_t angles
);

	localparam int L = qte_pkg::TOTAL_LAT;

	logic         en;
	logic [L-1:0] vld_q;

	assign en          = !vld_q[L-1] || angle_ready;
	assign quat_ready  = en;
	assign angle_valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], quat_valid && quat.quat_present};
		end
	end

	logic signed [63:0] wy_s1, xz_s1, yz_s1, wx_s1, xx_s1, yy_s1, xy_s1, wz_s1, ww_s1, zz_s1;

	function automatic logic signed [63:0] mq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p >>> 4;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			wy_s1 <= mq(quat.quat_w, quat.quat_y);
			xz_s1 <= mq(quat.quat_x, quat.quat_z);
			yz_s1 <= mq(quat.quat_y, quat.quat_z);
			wx_s1 <= mq(quat.quat_w, quat.quat_x);
			xx_s1 <= mq(quat.quat_x, quat.quat_x);
			yy_s1 <= mq(quat.quat_y, quat.quat_y);
			xy_s1 <= mq(quat.quat_x, quat.quat_y);
			wz_s1 <= mq(quat.quat_w, quat.quat_z);
			ww_s1 <= mq(quat.quat_w, quat.quat_w);
			zz_s1 <= mq(quat.quat_z, quat.quat_z);
		end
	end

	logic signed [63:0] s_s2, rny_s2, rnx_s2, yny_s2, ynx_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2   <= (wy_s1 - xz_s1) <<< 1;
			rny_s2 <= (yz_s1 + wx_s1) <<< 1;
			rnx_s2 <= qte_pkg::ONE_Q56 - ((xx_s1 + yy_s1) <<< 1);
			yny_s2 <= (xy_s1 + wz_s1) <<< 1;
			ynx_s2 <= ww_s1 + xx_s1 - yy_s1 - zz_s1;
		end
	end

	logic signed [63:0] s_sat;
	logic signed [63:0] s_shr;
	logic signed [29:0] s28_s3;

	always_comb begin
		if (s_s2 > qte_pkg::ONE_Q56) begin
			s_sat = qte_pkg::ONE_Q56;
		end else if (s_s2 < -qte_pkg::ONE_Q56) begin
			s_sat = -qte_pkg::ONE_Q56;
		end else begin
			s_sat = s_s2;
		end
		s_shr = s_sat >>> 28;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s28_s3 <= s_shr[29:0];
		end
	end

	logic signed [59:0] sq;
	logic signed [63:0] vfull;
	logic [56:0]        v_s4;

	assign sq    = s28_s3 * s28_s3;
	assign vfull = qte_pkg::ONE_Q56 - 64'(sq);

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4 <= vfull[56:0];
		end
	end

	logic signed [29:0] s28_d [qte_pkg::S28_DELAY];

	always_ff @(posedge clk) begin
		if (en) begin
			s28_d[0] <= s28_s3;
			for (int k = 1; k < qte_pkg::S28_DELAY; k++) begin
				s28_d[k] <= s28_d[k-1];
			end
		end
	end

	logic [28:0] root;

	qte_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.v_in (v_s4),
		.root (root)
	);

	logic signed [qte_pkg::ZW-1:0] z_pitch, z_roll, z_yaw;

	qte_cordic u_cordic_pitch (
		.clk   (clk),
		.en    (en),
		.y_in  (64'(s28_d[qte_pkg::S28_DELAY-1])),
		.x_in  ($signed({35'd0, root})),
		.z_out (z_pitch)
	);

	qte_cordic u_cordic_roll (
		.clk   (clk),
		.en    (en),
		.y_in  (rny_s2),
		.x_in  (rnx_s2),
		.z_out (z_roll)
	);

	qte_cordic u_cordic_yaw (
		.clk   (clk),
		.en    (en),
		.y_in  (yny_s2),
		.x_in  (ynx_s2),
		.z_out (z_yaw)
	);

	logic signed [qte_pkg::ZW-1:0] roll_d [qte_pkg::ROLL_DELAY];
	logic signed [qte_pkg::ZW-1:0] yaw_d [qte_pkg::ROLL_DELAY];

	always_ff @(posedge clk) begin
		if (en) begin
			roll_d[0] <= z_roll;
			yaw_d[0]  <= z_yaw;
			for (int k = 1; k < qte_pkg::ROLL_DELAY; k++) begin
				roll_d[k] <= roll_d[k-1];
				yaw_d[k]  <= yaw_d[k-1];
			end
		end
	end

	logic signed [qte_pkg::ZW-1:0] zl [3];
	logic        neg_sa [3];
	logic [48:0] p_sa [3];
	logic        neg_sb [3];
	logic [19:0] u_sb [3];
	logic [19:0] q0_sb [3];
	logic [15:0] res_sc [3];

	assign zl[0] = z_pitch;
	assign zl[1] = roll_d[qte_pkg::ROLL_DELAY-1];
	assign zl[2] = yaw_d[qte_pkg::ROLL_DELAY-1];

	for (genvar l = 0; l < 3; l++) begin : g_scale
		logic [qte_pkg::ZW-1:0] mag;
		logic [49:0]            t;
		logic [41:0]            qp;
		logic [19:0]            r;
		logic [19:0]            q;

		assign mag = zl[l] < 0 ? qte_pkg::ZW'(-zl[l]) : qte_pkg::ZW'(zl[l]);
		assign t   = 50'(p_sa[l]) + qte_pkg::SCALE_HALF;
		assign qp  = t[49:30] * qte_pkg::RECIP_5;
		assign r   = u_sb[l] - 20'(q0_sb[l] * 20'd5);
		assign q   = q0_sb[l] + 20'(r >= 20'd5);

		always_ff @(posedge clk) begin
			if (en) begin
				neg_sa[l] <= zl[l] < 0;
				p_sa[l]   <= 49'(mag[32:0] * qte_pkg::SCALE_NUM);
				neg_sb[l] <= neg_sa[l];
				u_sb[l]   <= t[49:30];
				q0_sb[l]  <= {2'b00, qp[41:24]};
				res_sc[l] <= neg_sb[l] ? 16'(-q) : q[15:0];
			end
		end
	end

	assign angles.pitch_angle = res_sc[0][14:0];
	assign angles.roll_angle  = res_sc[1];
	assign angles.yaw_angle   = res_sc[2];

endmodule

// File: hw/rtl/qte_checker.sv
// Port-level checks for the quaternion to Euler angle converter, bound to the top level
`include "quaternion_to_euler_angles_assert.svh"

module qte_port_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             quat_ready,
	input logic             angle_valid,
	input logic             angle_ready,
	input qte_pkg::angles_t angles
);

	logic pitch_ok;

	assign pitch_ok = (angles.pitch_angle >= -15'sd11521) && (angles.pitch_angle <= 15'sd11521);

	`QTE_ASSERT_NEXT(a_out_hold, angle_valid && !angle_ready, angle_valid)
	`QTE_ASSERT_NEXT(a_out_stable, angle_valid && !angle_ready, $stable(angles))
	`QTE_ASSERT_NOW(a_ready_free, !angle_valid || angle_ready, quat_ready)
	`QTE_ASSERT_NOW(a_pitch_range, angle_valid, pitch_ok)

endmodule

bind quaternion_to_euler_angles qte_port_checker u_qte_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.quat_ready  (quat_ready),
	.angle_valid (angle_valid),
	.angle_ready (angle_ready),
	.angles      (angles)
);

// File: dv/qte_checker.sv
// Checker for the quaternion to Euler angle converter: predicts angles and compares transfers
`timescale 1ns / 100ps
module qte_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             quat_valid,
	input  logic             quat_ready,
	input  qte_pkg::quat_t   quat,
	input  logic             angle_valid,
	input  logic             angle_ready,
	input  qte_pkg::angles_t angles,
	output int               fail_count,
	output int               pending
);
	import qte_pkg::*;

	localparam longint HALF_PI = 64'sd1686629713;
	localparam longint ONE56 = 64'sd1 << 56;

	angles_t expected_angles[$];

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint mul_q56(longint a, longint b);
		return floor_shr(a * b, 4);
	endfunction

	function automatic longint int_sqrt(longint v);
		longint res;
		longint bit_val;
		res = 0;
		bit_val = 64'sd1 << 62;
		while (bit_val > v)
			bit_val = bit_val >> 2;
		while (bit_val != 0) begin
			if (v >= res + bit_val) begin
				v = v - (res + bit_val);
				res = (res >> 1) + bit_val;
			end else begin
				res = res >> 1;
			end
			bit_val = bit_val >> 2;
		end
		return res;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint acc;
		longint t;
		longint xs;
		longint ys;
		acc = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				acc = HALF_PI;
			end else begin
				x = -y;
				y = t;
				acc = -HALF_PI;
			end
		end
		for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				acc = acc + longint'(ATAN_Q30[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				acc = acc - longint'(ATAN_Q30[i]);
			end
		end
		return acc;
	endfunction

	function automatic logic [15:0] degrees_128(longint rad);
		logic [63:0] mag;
		logic [63:0] q;
		mag = (rad < 0) ? -rad : rad;
		q = (mag * 64'd36672 + 64'd2684354560) / 64'd5368709120;
		if (rad < 0)
			q = -q;
		return q[15:0];
	endfunction

	function automatic angles_t euler_of(quat_t q);
		angles_t a;
		longint w, x, y, z, s, s28, c28, ny, nx;
		logic [15:0] p;
		w = q.quat_w;
		x = q.quat_x;
		y = q.quat_y;
		z = q.quat_z;
		s = 2 * (mul_q56(w, y) - mul_q56(x, z));
		if (s > ONE56)
			s = ONE56;
		if (s < -ONE56)
			s = -ONE56;
		s28 = floor_shr(s, 28);
		c28 = int_sqrt(ONE56 - s28 * s28);
		p = degrees_128(vector_angle(s28, c28));
		a.pitch_angle = p[14:0];
		ny = 2 * (mul_q56(y, z) + mul_q56(w, x));
		nx = ONE56 - 2 * (mul_q56(x, x) + mul_q56(y, y));
		a.roll_angle = degrees_128(vector_angle(ny, nx));
		ny = 2 * (mul_q56(x, y) + mul_q56(w, z));
		nx = mul_q56(w, w) + mul_q56(x, x) - mul_q56(y, y) - mul_q56(z, z);
		a.yaw_angle = degrees_128(vector_angle(ny, nx));
		return a;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		angles_t e;
		if (arst_n) begin
			if (quat_valid && quat_ready && quat.quat_present)
				expected_angles.push_back(euler_of(quat));
			if (angle_valid && angle_ready) begin
				if (expected_angles.size() == 0) begin
					report_mismatch("unexpected transfer", 1, 0);
				end else begin
					e = expected_angles.pop_front();
					if (angles.pitch_angle !== e.pitch_angle)
						report_mismatch("pitch", angles.pitch_angle, e.pitch_angle);
					if (angles.roll_angle !== e.roll_angle)
						report_mismatch("roll", angles.roll_angle, e.roll_angle);
					if (angles.yaw_angle !== e.yaw_angle)
						report_mismatch("yaw", angles.yaw_angle, e.yaw_angle);
				end
			end
			pending = expected_angles.size();
		end
	end
endmodule

// File: dv/tb_quaternion_to_euler_angles.sv
// Testbench top for the quaternion to Euler angle converter: stimulus, stalls and verdict
`timescale 1ns / 100ps
module tb_quaternion_to_euler_angles;
	import qte_pkg::*;

	logic clk;
	logic arst_n;
	logic quat_valid;
	logic quat_ready;
	quat_t quat;
	logic angle_valid;
	logic angle_ready;
	angles_t angles;
	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;
	bit stim_done;

	quaternion_to_euler_angles dut (
		.clk(clk), .arst_n(arst_n),
		.quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat),
		.angle_valid(angle_valid), .angle_ready(angle_ready), .angles(angles)
	);

	qte_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat),
		.angle_valid(angle_valid), .angle_ready(angle_ready), .angles(angles),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_ready <= 1'b0;
		end else begin
			angle_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [31:0] rand_comp(int kind);
		case (kind)
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'h4000_0000;
			4: return 32'hC000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic quat_t unit_quat();
		quat_t q;
		real a, b, c, d, n;
		a = real'($urandom_range(2000)) - 1000.0;
		b = real'($urandom_range(2000)) - 1000.0;
		c = real'($urandom_range(2000)) - 1000.0;
		d = real'($urandom_range(2000)) - 1000.0;
		n = $sqrt(a * a + b * b + c * c + d * d) + 0.001;
		q.quat_w = $rtoi(a / n * 1073741000.0);
		q.quat_x = $rtoi(b / n * 1073741000.0);
		q.quat_y = $rtoi(c / n * 1073741000.0);
		q.quat_z = $rtoi(d / n * 1073741000.0);
		q.quat_present = 1'b1;
		return q;
	endfunction

	task automatic send(quat_t q);
		quat_valid <= 1'b1;
		quat <= q;
		@(posedge clk);
		while (!quat_ready)
			@(posedge clk);
	endtask

	task automatic send_gap();
		while ($urandom_range(99) < send_idle_pct) begin
			quat_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		quat_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (TOTAL_LAT + 10) @(posedge clk);
	endtask

	initial begin
		quat_t q;
		int r;
		arst_n = 1'b0;
		quat_valid = 1'b0;
		quat = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		stim_done = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// extremes and special cases
		for (int k = 0; k < 6; k++) begin
			q.quat_w = rand_comp(k);
			q.quat_x = rand_comp((k + 1) % 6);
			q.quat_y = rand_comp((k + 2) % 6);
			q.quat_z = rand_comp((k + 3) % 6);
			q.quat_present = 1'b1;
			send(q);
		end
		send('{32'sh4000_0000, 0, 0, 0, 1'b1});
		send('{0, 0, 0, 0, 1'b1});
		send('{32'sh2D41_3CCC, 0, 32'sh2D41_3CCC, 0, 1'b1});
		send('{32'sh2D41_3CCC, 0, 32'shD2BE_C334, 0, 1'b1});
		send('{32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 0, 1'b1});
		send('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1});
		send('{0, 32'sh4000_0000, 0, 0, 1'b1});
		send('{0, 0, 0, 32'sh4000_0000, 1'b1});
		send('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0});
		send('{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h8765_4321, 1'b1});
		drain();
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 78; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 78; end
				3: begin send_idle_pct = 35; recv_stall_pct = 35; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1; end
			endcase
			for (int n = 0; n < 190; n++) begin
				r = $urandom_range(99);
				if (r < 70) begin
					q = unit_quat();
				end else begin
					q.quat_w = rand_comp($urandom_range(8));
					q.quat_x = rand_comp($urandom_range(8));
					q.quat_y = rand_comp($urandom_range(8));
					q.quat_z = rand_comp($urandom_range(8));
					q.quat_present = $urandom_range(3) != 0;
				end
				send_gap();
				send(q);
			end
			drain();
		end
		stim_done = 1;
	end

	// long receiver hold-off in the last phase so the pipeline fills and stalls input
	initial begin
		wait (hold_off);
		repeat (300) @(posedge clk);
		hold_off = 0;
	end

	initial begin
		wait (stim_done);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
